// ===== src/tvbb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvbb_pkg
// Shared types and constants of the transformed vertex bounding box block.
// ----------------------------------------------------------------------------
package tvbb_pkg;

  // Number of spatial axes.
  localparam int AXES = 3;

  // Coordinate and coefficient formats.
  localparam int COORD_W        = 32;
  localparam int COEF_W         = 16;
  localparam int ROW_W          = AXES * COEF_W;
  localparam int PROD_W         = COEF_W + COORD_W;
  localparam int ACC_W          = PROD_W + 2;
  localparam int COEF_FRAC_BITS = 12;
  localparam int SHR_W          = ACC_W - COEF_FRAC_BITS;
  localparam int SUM_W          = SHR_W + 1;

  // Configuration port geometry.
  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;
  localparam int IDX_LSB = 3;
  localparam int IDX_W   = PADDR_W - IDX_LSB;

  // Register map, by index.
  typedef enum logic [IDX_W-1:0] {
    REG_ROW_X,
    REG_ROW_Y,
    REG_ROW_Z,
    REG_TR_X,
    REG_TR_Y,
    REG_TR_Z
  } reg_idx_t;

  // Reset values: identity matrix in Q4.12, zero translation.
  localparam logic [ROW_W-1:0] ROW_X_RESET = 48'h0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW_Y_RESET = 48'h0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW_Z_RESET = 48'h1000_0000_0000;

  // Bounds of a saturated coordinate; also the empty box.
  localparam logic [COORD_W-1:0] COORD_MAX = 32'h7fff_ffff;
  localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef coord_t [AXES-1:0]  coord_vec_t;

  // Transform configuration as seen by the datapath.
  typedef struct packed {
    row_t   [AXES-1:0] row;
    coord_t [AXES-1:0] trans;
  } xform_cfg_t;

  // Control that travels with a vertex beat down the pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } beat_ctl_t;

endpackage

// ===== src/tvbb_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvbb_cfg_regs
// APB-style register file holding the affine transform configuration.
// ----------------------------------------------------------------------------
module tvbb_cfg_regs
  import tvbb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output xform_cfg_t         cfg
);

  reg_idx_t idx;
  logic     wr_en;

  // The register index comes from the 8-byte aligned address.
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:IDX_LSB]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes; unmapped indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row[0] <= ROW_X_RESET;
      cfg.row[1] <= ROW_Y_RESET;
      cfg.row[2] <= ROW_Z_RESET;
      cfg.trans  <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_ROW_X: cfg.row[0]   <= pwdata[ROW_W-1:0];
        REG_ROW_Y: cfg.row[1]   <= pwdata[ROW_W-1:0];
        REG_ROW_Z: cfg.row[2]   <= pwdata[ROW_W-1:0];
        REG_TR_X:  cfg.trans[0] <= pwdata[COORD_W-1:0];
        REG_TR_Y:  cfg.trans[1] <= pwdata[COORD_W-1:0];
        REG_TR_Z:  cfg.trans[2] <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux; unmapped indexes read as zero.
  always_comb begin
    case (idx)
      REG_ROW_X: prdata = {{(PDATA_W-ROW_W){1'b0}}, cfg.row[0]};
      REG_ROW_Y: prdata = {{(PDATA_W-ROW_W){1'b0}}, cfg.row[1]};
      REG_ROW_Z: prdata = {{(PDATA_W-ROW_W){1'b0}}, cfg.row[2]};
      REG_TR_X:  prdata = {{(PDATA_W-COORD_W){1'b0}}, cfg.trans[0]};
      REG_TR_Y:  prdata = {{(PDATA_W-COORD_W){1'b0}}, cfg.trans[1]};
      REG_TR_Z:  prdata = {{(PDATA_W-COORD_W){1'b0}}, cfg.trans[2]};
      default:   prdata = '0;
    endcase
  end

endmodule

// ===== src/tvbb_transform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvbb_transform
// Three-stage affine transform: input register, registered products, and a
// sum, floor shift, translate and saturate stage.
// ----------------------------------------------------------------------------
module tvbb_transform
  import tvbb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         adv,
  input  logic         vertex_valid,
  input  logic [31:0]  vertex_x,
  input  logic [31:0]  vertex_y,
  input  logic [31:0]  vertex_z,
  input  logic         last_vertex,
  input  xform_cfg_t   cfg,
  output beat_ctl_t    xf_ctl,
  output coord_vec_t   xf_coord
);

  beat_ctl_t  ctl1;
  beat_ctl_t  ctl2;
  coord_vec_t vtx;

  logic signed [PROD_W-1:0] prod      [AXES][AXES];
  logic signed [PROD_W-1:0] prod_next [AXES][AXES];
  logic signed [ACC_W-1:0]  acc       [AXES];
  logic signed [SUM_W-1:0]  sum       [AXES];
  logic [SUM_W-COORD_W:0]   sum_hi    [AXES];
  coord_vec_t               coord_next;

  // Pipeline control; every stage moves together when the pipe advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1   <= '0;
      ctl2   <= '0;
      xf_ctl <= '0;
    end else if (adv) begin
      ctl1   <= '{valid: vertex_valid, last: last_vertex};
      ctl2   <= ctl1;
      xf_ctl <= ctl2;
    end
  end

  // Coefficient by coordinate products, nine of them, one per matrix entry.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      for (int k = 0; k < AXES; k++) begin
        prod_next[a][k] = $signed(cfg.row[a][COEF_W*k +: COEF_W]) * $signed(vtx[k]);
      end
    end
  end

  // Exact row sum, floor shift back to Q16.16, translate, then saturate.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      acc[a] = $signed({{2{prod[a][0][PROD_W-1]}}, prod[a][0]})
             + $signed({{2{prod[a][1][PROD_W-1]}}, prod[a][1]})
             + $signed({{2{prod[a][2][PROD_W-1]}}, prod[a][2]});
      sum[a] = $signed({acc[a][ACC_W-1], acc[a][ACC_W-1:COEF_FRAC_BITS]})
             + $signed({{(SUM_W-COORD_W){cfg.trans[a][COORD_W-1]}}, cfg.trans[a]});
      sum_hi[a] = sum[a][SUM_W-1:COORD_W-1];
      if ((&sum_hi[a]) || !(|sum_hi[a])) begin
        coord_next[a] = sum[a][COORD_W-1:0];
      end else if (sum[a][SUM_W-1]) begin
        coord_next[a] = COORD_MIN;
      end else begin
        coord_next[a] = COORD_MAX;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      vtx      <= {vertex_z, vertex_y, vertex_x};
      prod     <= prod_next;
      xf_coord <= coord_next;
    end
  end

endmodule

// ===== src/tvbb_box.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvbb_box
// Running per-axis min and max, and the box result register with its size
// and center.
// ----------------------------------------------------------------------------
module tvbb_box
  import tvbb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  beat_ctl_t  xf_ctl,
  input  coord_vec_t xf_coord,
  input  logic       box_stall,
  output logic       adv,
  output logic       box_valid,
  output coord_vec_t box_min,
  output coord_vec_t box_max,
  output coord_vec_t box_size,
  output coord_vec_t box_center
);

  coord_vec_t         run_min;
  coord_vec_t         run_max;
  coord_vec_t         fold_min;
  coord_vec_t         fold_max;
  logic               emit;
  logic [COORD_W:0]   csum [AXES];

  // The pipe holds only when a new box is due while the last one still waits.
  assign adv  = !(xf_ctl.valid && xf_ctl.last && box_valid && box_stall);
  assign emit = adv && xf_ctl.valid && xf_ctl.last;

  // Fold the incoming coordinate into the running box.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      fold_min[a] = ($signed(xf_coord[a]) < $signed(run_min[a])) ? xf_coord[a] : run_min[a];
      fold_max[a] = ($signed(xf_coord[a]) > $signed(run_max[a])) ? xf_coord[a] : run_max[a];
    end
  end

  // Running box and result valid; an emitted box clears to empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_min   <= {AXES{COORD_MAX}};
      run_max   <= {AXES{COORD_MIN}};
      box_valid <= 1'b0;
    end else begin
      if (adv && xf_ctl.valid) begin
        if (xf_ctl.last) begin
          run_min <= {AXES{COORD_MAX}};
          run_max <= {AXES{COORD_MIN}};
        end else begin
          run_min <= fold_min;
          run_max <= fold_max;
        end
      end
      if (emit) begin
        box_valid <= 1'b1;
      end else if (!box_stall) begin
        box_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      box_min <= fold_min;
      box_max <= fold_max;
    end
  end

  // Size and floor-halved center from the held result.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      box_size[a]   = box_max[a] - box_min[a];
      csum[a]       = {box_max[a][COORD_W-1], box_max[a]} + {box_min[a][COORD_W-1], box_min[a]};
      box_center[a] = csum[a][COORD_W:1];
    end
  end

  // A delivered box always contains its last vertex, so min never exceeds max.
  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    box_valid |-> ($signed(box_min[0]) <= $signed(box_max[0]))
               && ($signed(box_min[1]) <= $signed(box_max[1]))
               && ($signed(box_min[2]) <= $signed(box_max[2])))
    else $error("box result has min above max");

  // Emitting a box presents it and leaves the running box empty.
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit |=> box_valid && (run_min == {AXES{COORD_MAX}}) && (run_max == {AXES{COORD_MIN}}))
    else $error("emit did not present the box or clear the running box");

  // A vertex that is not last never holds the pipe.
  a_plain_flows: assert property (@(posedge clk) disable iff (rst)
    (xf_ctl.valid && !xf_ctl.last) |-> adv)
    else $error("pipe held for a vertex that is not last");

  // While the pipe holds, the running box does not move.
  a_hold_keeps_box: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(run_min) && $stable(run_max))
    else $error("running box changed while the pipe was held");

endmodule

// ===== src/transformed_vertex_bounding_box_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transformed_vertex_bounding_box_top
// Axis-aligned bounding box of a vertex stream after an affine transform.
// ----------------------------------------------------------------------------
// The block takes one vertex beat per clock cycle. Each vertex goes through a
// four-stage pipeline: an input register, a stage of nine registered 16x32
// coefficient products, a stage that sums each row, floors it back to Q16.16,
// adds the translation and saturates, and the min/max fold. The box result is
// registered by the fold stage when the last vertex is accepted there, and is
// held until taken. vertex_stall rises only when a last vertex reaches the
// fold stage while the previous box still waits on box_stall; otherwise one
// vertex enters in every cycle. Configuration is written through the APB port
// at byte address 8*i and should be changed only while no vertex is in flight.
// ----------------------------------------------------------------------------
module transformed_vertex_bounding_box_top
  import tvbb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // Vertex channel.
  input  logic               vertex_valid,
  output logic               vertex_stall,
  input  logic [31:0]        vertex_x,
  input  logic [31:0]        vertex_y,
  input  logic [31:0]        vertex_z,
  input  logic               last_vertex,
  // Box channel.
  output logic               box_valid,
  input  logic               box_stall,
  output logic [31:0]        min_x,
  output logic [31:0]        min_y,
  output logic [31:0]        min_z,
  output logic [31:0]        max_x,
  output logic [31:0]        max_y,
  output logic [31:0]        max_z,
  output logic [31:0]        size_x,
  output logic [31:0]        size_y,
  output logic [31:0]        size_z,
  output logic [31:0]        center_x,
  output logic [31:0]        center_y,
  output logic [31:0]        center_z
);

  xform_cfg_t cfg;
  beat_ctl_t  xf_ctl;
  coord_vec_t xf_coord;
  coord_vec_t box_min;
  coord_vec_t box_max;
  coord_vec_t box_size;
  coord_vec_t box_center;
  logic       adv;

  // Configuration registers.
  tvbb_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Transform pipeline.
  tvbb_transform u_xf (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .vertex_valid (vertex_valid),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .vertex_z     (vertex_z),
    .last_vertex  (last_vertex),
    .cfg          (cfg),
    .xf_ctl       (xf_ctl),
    .xf_coord     (xf_coord)
  );

  // Running box and result.
  tvbb_box u_box (
    .clk        (clk),
    .rst        (rst),
    .xf_ctl     (xf_ctl),
    .xf_coord   (xf_coord),
    .box_stall  (box_stall),
    .adv        (adv),
    .box_valid  (box_valid),
    .box_min    (box_min),
    .box_max    (box_max),
    .box_size   (box_size),
    .box_center (box_center)
  );

  // A vertex beat is taken whenever the pipe advances.
  assign vertex_stall = !adv;

  // Split the result vectors onto the field ports.
  assign min_x    = box_min[0];
  assign min_y    = box_min[1];
  assign min_z    = box_min[2];
  assign max_x    = box_max[0];
  assign max_y    = box_max[1];
  assign max_z    = box_max[2];
  assign size_x   = box_size[0];
  assign size_y   = box_size[1];
  assign size_z   = box_size[2];
  assign center_x = box_center[0];
  assign center_y = box_center[1];
  assign center_z = box_center[2];

endmodule
